@@ sv/bfblit_pkg.sv @@
// ============================================================================
// bfblit_pkg
// Shared types, constants and the glyph lookup of the bitmap font text blitter.
// ============================================================================
package bfblit_pkg;

    // default geometry
    localparam int TILE_SIZE_DEF     = 8;
    localparam int ATLAS_WIDTH_DEF   = 256;
    localparam int ATLAS_HEIGHT_DEF  = 32;
    localparam int CANVAS_WIDTH_DEF  = 512;
    localparam int CANVAS_HEIGHT_DEF = 32;

    // field widths
    localparam int KIND_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int PEN_X_W      = 9;
    localparam int PEN_Y_W      = 5;
    localparam int TEXEL_ADDR_W = 13;
    localparam int TEXEL_W      = 32;
    localparam int OUT_X_W      = 10;
    localparam int OUT_Y_W      = 7;
    localparam int RGBA_W       = 32;
    localparam int PEN_W        = 10;
    localparam int ADV_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int SUM_W        = 16;
    localparam int GLYPH_COL_W  = 5;
    localparam int GLYPH_ROW_W  = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_ADV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_I_ADV       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ADV = 2'd2;

    // register reset values
    localparam logic [ADV_W-1:0] NARROW_ADV_RST  = 4'd4;
    localparam logic [ADV_W-1:0] I_ADV_RST       = 4'd6;
    localparam logic [ADV_W-1:0] DEFAULT_ADV_RST = 4'd7;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    // character codes
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'd48;
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'd57;
    localparam logic [CHAR_W-1:0] CH_LO_P  = 8'h70;
    localparam logic [CHAR_W-1:0] CH_LO_G  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LO_J  = 8'h6A;
    localparam logic [CHAR_W-1:0] CH_LO_L  = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_R  = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LO_I  = 8'h69;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

    // atlas tile of a character
    typedef struct packed {
        logic                   hit;
        logic [GLYPH_COL_W-1:0] col;
        logic [GLYPH_ROW_W-1:0] row;
        logic                   drop;
    } glyph_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic row_end;
        logic last;
        logic clr_we;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic adv;
        logic empty;
        logic clr_last;
    } sts_t;

    // character to tile lookup
    function automatic glyph_t map_glyph(input logic [CHAR_W-1:0] c);
        glyph_t g;
        g = '0;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            g.hit = 1'b1;
            g.col = GLYPH_COL_W'(c - CH_UP_A);
            g.row = 2'd0;
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            g.hit  = 1'b1;
            g.col  = GLYPH_COL_W'(c - CH_LO_A);
            g.row  = 2'd1;
            g.drop = (c == CH_LO_P) || (c == CH_LO_G) || (c == CH_LO_J);
        end
        else if (c >= CH_DIG_0 && c <= CH_DIG_9)
        begin
            g.hit  = 1'b1;
            g.col  = GLYPH_COL_W'(c - CH_DIG_0);
            g.row  = 2'd2;
            g.drop = 1'b1;
        end
        else
        begin
            g.row = 2'd3;
            g.hit = 1'b1;
            case (c)
                CH_COLON:
                begin
                    g.col  = 5'd0;
                    g.drop = 1'b1;
                end
                CH_MINUS:  g.col = 5'd3;
                CH_SLASH:  g.col = 5'd4;
                CH_BSLASH: g.col = 5'd5;
                CH_LPAREN: g.col = 5'd8;
                CH_RPAREN: g.col = 5'd9;
                CH_DOT:    g.col = 5'd10;
                default:   g.hit = 1'b0;
            endcase
        end
        return g;
    endfunction

endpackage

@@ sv/bfblit_if.sv @@
// ============================================================================
// bfblit_if
// Valid/ready channels of the blitter: input items and emitted pixels.
// ============================================================================

// input item channel
interface bfblit_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [bfblit_pkg::KIND_W-1:0]         kind;
    logic [bfblit_pkg::CHAR_W-1:0]         char_code;
    logic                                  start_line;
    logic [bfblit_pkg::PEN_X_W-1:0]        pen_x;
    logic [bfblit_pkg::PEN_Y_W-1:0]        pen_y;
    logic [bfblit_pkg::TEXEL_ADDR_W-1:0]   texel_addr;
    logic [bfblit_pkg::TEXEL_W-1:0]        texel_data;

    modport source (
        output valid, kind, char_code, start_line, pen_x, pen_y, texel_addr, texel_data,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, start_line, pen_x, pen_y, texel_addr, texel_data,
        output ready
    );
endinterface

// pixel result channel
interface bfblit_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [bfblit_pkg::OUT_X_W-1:0]       out_x;
    logic signed [bfblit_pkg::OUT_Y_W-1:0] out_y;
    logic [bfblit_pkg::RGBA_W-1:0]        out_rgba;
    logic                                 clipped;
    logic                                 last;

    modport source (
        output valid, out_x, out_y, out_rgba, clipped, last,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_rgba, clipped, last,
        output ready
    );
endinterface

@@ sv/bitmap_font_text_blitter.sv @@
// ============================================================================
// bitmap_font_text_blitter
// Text renderer: font atlas load, canvas clear and alpha-blended glyph draw.
// ============================================================================
// A load item writes one atlas texel. A draw item walks its TILE_SIZE x
// TILE_SIZE tile one pixel per cycle while the pixel sink does not stall,
// through the canvas read and write ports (read, blend, divide, write back);
// an unmapped character only moves the pen. A clear item, and reset, run a
// clearing pass over all CANVAS_WIDTH*CANVAS_HEIGHT canvas entries (16384 by
// default), one entry per cycle, during which no item is accepted;
// configuration writes are taken at any time.
// The atlas holds undefined data until its texels are loaded.
module bitmap_font_text_blitter #(
    parameter int TILE_SIZE     = bfblit_pkg::TILE_SIZE_DEF,
    parameter int ATLAS_WIDTH   = bfblit_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT  = bfblit_pkg::ATLAS_HEIGHT_DEF,
    parameter int CANVAS_WIDTH  = bfblit_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = bfblit_pkg::CANVAS_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bfblit_in_if.sink                          item,
    bfblit_out_if.source                       pixel,
    input  logic                               cfg_we,
    input  logic [bfblit_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfblit_pkg::ADV_W-1:0]       cfg_data
);

    bfblit_pkg::cmd_t cmd;
    bfblit_pkg::sts_t sts;

    // sequencer
    bfblit_ctrl #(
        .TILE_SIZE (TILE_SIZE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .sts   (sts)
    );

    // memories and pixel pipeline
    bfblit_dp #(
        .TILE_SIZE     (TILE_SIZE),
        .ATLAS_WIDTH   (ATLAS_WIDTH),
        .ATLAS_HEIGHT  (ATLAS_HEIGHT),
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .kind       (item.kind),
        .char_code  (item.char_code),
        .start_line (item.start_line),
        .pen_x      (item.pen_x),
        .pen_y      (item.pen_y),
        .texel_addr (item.texel_addr),
        .texel_data (item.texel_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel)
    );

endmodule

@@ sv/bfblit_ctrl.sv @@
// ============================================================================
// bfblit_ctrl
// Sequencer: canvas clearing sweep, item acceptance and per-pixel issue of
// a glyph tile in row-major order.
// ============================================================================
module bfblit_ctrl #(
    parameter int TILE_SIZE = bfblit_pkg::TILE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bfblit_in_if.sink          item,
    output bfblit_pkg::cmd_t   cmd,
    input  bfblit_pkg::sts_t   sts
);

    localparam int TW = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam logic [TW-1:0] TILE_END = TW'(TILE_SIZE - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW
    } state_t;

    state_t              state_reg, state_next;
    logic [TW-1:0]       row_reg, row_next;
    logic [TW-1:0]       col_reg, col_next;
    logic                accept;
    bfblit_pkg::glyph_t  glyph;

    assign glyph = bfblit_pkg::map_glyph(item.char_code);

    // new items only with an empty pixel pipeline
    assign item.ready = (state_reg == ST_IDLE) && sts.empty;
    assign accept     = item.valid && item.ready;

    // commands
    always_comb
    begin
        cmd.accept  = accept;
        cmd.issue   = (state_reg == ST_DRAW) && sts.adv;
        cmd.row_end = (col_reg == TILE_END);
        cmd.last    = (col_reg == TILE_END) && (row_reg == TILE_END);
        cmd.clr_we  = (state_reg == ST_CLEAR);
    end

    // next state and tile counters
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && item.kind == bfblit_pkg::KIND_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && item.kind == bfblit_pkg::KIND_DRAW && glyph.hit)
                begin
                    state_next = ST_DRAW;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_DRAW:
            begin
                if (cmd.issue)
                begin
                    if (cmd.row_end)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                        if (cmd.last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, clearing pass starts from reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // a clear item starts the sweep
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == bfblit_pkg::KIND_CLEAR) |=> (state_reg == ST_CLEAR))
        else $error("clear item did not start the sweep");

    // a mapped glyph starts at the first tile texel
    a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == bfblit_pkg::KIND_DRAW && glyph.hit)
        |=> (state_reg == ST_DRAW && row_reg == '0 && col_reg == '0))
        else $error("glyph did not start at tile origin");

    // issue of the final texel ends the glyph
    a_draw_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("glyph did not end after last texel");

endmodule

@@ sv/bfblit_dp.sv @@
// ============================================================================
// bfblit_dp
// Datapath: atlas and canvas memories, pen and advance registers, tile
// address walkers and the read / blend / divide / write pixel pipeline.
// ============================================================================
module bfblit_dp #(
    parameter int TILE_SIZE     = bfblit_pkg::TILE_SIZE_DEF,
    parameter int ATLAS_WIDTH   = bfblit_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT  = bfblit_pkg::ATLAS_HEIGHT_DEF,
    parameter int CANVAS_WIDTH  = bfblit_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = bfblit_pkg::CANVAS_HEIGHT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bfblit_pkg::cmd_t                       cmd,
    output bfblit_pkg::sts_t                       sts,
    input  logic [bfblit_pkg::KIND_W-1:0]          kind,
    input  logic [bfblit_pkg::CHAR_W-1:0]          char_code,
    input  logic                                   start_line,
    input  logic [bfblit_pkg::PEN_X_W-1:0]         pen_x,
    input  logic [bfblit_pkg::PEN_Y_W-1:0]         pen_y,
    input  logic [bfblit_pkg::TEXEL_ADDR_W-1:0]    texel_addr,
    input  logic [bfblit_pkg::TEXEL_W-1:0]         texel_data,
    input  logic                                   cfg_we,
    input  logic [bfblit_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfblit_pkg::ADV_W-1:0]           cfg_data,
    bfblit_out_if.source                           pixel
);

    localparam int ADEPTH = ATLAS_WIDTH * ATLAS_HEIGHT;
    localparam int CDEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int AIDX_W = $clog2(ADEPTH);
    localparam int CIDX_W = $clog2(CDEPTH);
    localparam int AROW_W = $clog2(ATLAS_HEIGHT) + 2;
    localparam int ACOL_W = $clog2(26 * TILE_SIZE);
    localparam int PEN_W  = bfblit_pkg::PEN_W;
    localparam int CX_W   = bfblit_pkg::PEN_W + 1;
    localparam int Y_W    = bfblit_pkg::OUT_Y_W;
    localparam int SUM_W  = bfblit_pkg::SUM_W;
    localparam logic [AIDX_W-1:0] A_ROW_STEP = AIDX_W'(ATLAS_WIDTH - TILE_SIZE + 1);
    localparam logic [CIDX_W-1:0] C_ROW_STEP = CIDX_W'(CANVAS_WIDTH - TILE_SIZE + 1);
    localparam logic [CIDX_W-1:0] C_LAST     = CIDX_W'(CDEPTH - 1);

    typedef struct packed {
        logic [bfblit_pkg::OUT_X_W-1:0] x;
        logic [Y_W-1:0]                 y;
        logic                           off;
        logic                           last;
    } meta_t;

    // blend numerator of one channel
    function automatic logic [SUM_W-1:0] blend_sum(input logic [7:0] src,
                                                   input logic [7:0] dst,
                                                   input logic [7:0] a);
        logic [SUM_W-1:0] p_src;
        logic [SUM_W-1:0] p_dst;
        p_src = SUM_W'(src) * SUM_W'(a);
        p_dst = SUM_W'(dst) * SUM_W'(bfblit_pkg::ALPHA_MAX - a);
        return p_src + p_dst;
    endfunction

    // floor(x / 255) as (x * 257 + 257) >> 16, exact below 65280
    function automatic logic [7:0] div255(input logic [SUM_W-1:0] x);
        logic [24:0] t;
        t = 25'(x) + {1'b0, x, 8'b0} + 25'd257;
        return t[23:16];
    endfunction

    // memories
    logic [bfblit_pkg::TEXEL_W-1:0] atlas_mem  [ADEPTH];
    logic [bfblit_pkg::RGBA_W-1:0]  canvas_mem [CDEPTH];

    // configuration and pen
    logic [bfblit_pkg::ADV_W-1:0] narrow_reg, iadv_reg, dadv_reg;
    logic [PEN_W-1:0]             pen_reg;
    logic [CIDX_W-1:0]            clr_cnt_reg;

    // tile walkers
    logic signed [AROW_W-1:0] arow_reg;
    logic [ACOL_W-1:0]        acol_reg, col0_reg;
    logic [AIDX_W-1:0]        aidx_reg;
    logic [CX_W-1:0]          cx_reg;
    logic [PEN_W-1:0]         x0_reg;
    logic signed [Y_W-1:0]    cy_reg;
    logic [CIDX_W-1:0]        cidx_reg;

    // pipeline
    logic                           s1_valid_reg, s2_valid_reg, o_valid_reg;
    meta_t                          s1_meta_reg, s2_meta_reg;
    logic                           s1_atl_ok_reg;
    logic [CIDX_W-1:0]              s1_cidx_reg, s2_cidx_reg;
    logic [bfblit_pkg::TEXEL_W-1:0] atl_q_reg;
    logic [bfblit_pkg::RGBA_W-1:0]  cvs_q_reg;
    logic [7:0]                     s2_alpha_reg;
    logic [SUM_W-1:0]               s2_sum_reg [3];
    logic [bfblit_pkg::OUT_X_W-1:0] o_x_reg;
    logic [Y_W-1:0]                 o_y_reg;
    logic [bfblit_pkg::RGBA_W-1:0]  o_rgba_reg;
    logic                           o_clip_reg;
    logic                           o_last_reg;

    // combinational
    bfblit_pkg::glyph_t             glyph;
    logic                           draw_acc;
    logic [PEN_W-1:0]               x0;
    logic [bfblit_pkg::ADV_W-1:0]   adv_amt;
    logic signed [AROW_W-1:0]       row0;
    logic [ACOL_W-1:0]              col0;
    logic signed [Y_W-1:0]          y0;
    logic [AIDX_W-1:0]              aidx0;
    logic [CIDX_W-1:0]              cidx0;
    logic                           atl_ok;
    logic                           off;
    logic                           adv;
    logic [bfblit_pkg::TEXEL_W-1:0] texel;
    logic [bfblit_pkg::RGBA_W-1:0]  blended;
    logic                           blend_we;
    logic                           cvs_we;
    logic [CIDX_W-1:0]              cvs_waddr;
    logic [bfblit_pkg::RGBA_W-1:0]  cvs_wdata;
    logic                           atl_we;

    // glyph setup from the accepted item
    always_comb
    begin
        glyph    = bfblit_pkg::map_glyph(char_code);
        draw_acc = cmd.accept && (kind == bfblit_pkg::KIND_DRAW);
        x0       = start_line ? PEN_W'(pen_x) : pen_reg;
        row0     = AROW_W'(ATLAS_HEIGHT - TILE_SIZE * (int'(glyph.row) + 1));
        col0     = ACOL_W'(int'(glyph.col) * TILE_SIZE);
        y0       = Y_W'(int'(pen_y) - int'(glyph.drop));
        aidx0    = AIDX_W'(int'(row0) * ATLAS_WIDTH + int'(col0));
        cidx0    = CIDX_W'(int'(y0) * CANVAS_WIDTH + int'(x0));
        if (char_code == bfblit_pkg::CH_LO_L || char_code == bfblit_pkg::CH_LO_F
            || char_code == bfblit_pkg::CH_LO_R)
        begin
            adv_amt = narrow_reg;
        end
        else if (char_code == bfblit_pkg::CH_LO_I)
        begin
            adv_amt = iadv_reg;
        end
        else
        begin
            adv_amt = dadv_reg;
        end
    end

    // range checks of the pixel being issued
    always_comb
    begin
        atl_ok = (int'(arow_reg) >= 0) && (int'(arow_reg) < ATLAS_HEIGHT)
                 && (int'(acol_reg) < ATLAS_WIDTH);
        off    = (int'(cx_reg) >= CANVAS_WIDTH) || (int'(cy_reg) < 0)
                 || (int'(cy_reg) >= CANVAS_HEIGHT);
    end

    // pipeline moves whenever the output beat is free or taken
    assign adv = !o_valid_reg || pixel.ready;

    // blend inputs and divide outputs
    always_comb
    begin
        texel   = s1_atl_ok_reg ? atl_q_reg : '0;
        blended = {s2_alpha_reg, div255(s2_sum_reg[2]), div255(s2_sum_reg[1]),
                   div255(s2_sum_reg[0])};
    end

    // canvas write port shared by blend write-back and clearing sweep
    always_comb
    begin
        blend_we  = adv && s2_valid_reg && !s2_meta_reg.off;
        cvs_we    = blend_we || cmd.clr_we;
        cvs_waddr = cmd.clr_we ? clr_cnt_reg : s2_cidx_reg;
        cvs_wdata = cmd.clr_we ? '0 : blended;
        atl_we    = cmd.accept && (kind == bfblit_pkg::KIND_LOAD)
                    && (int'(texel_addr) < ADEPTH);
    end

    // atlas memory
    always_ff @(posedge clk)
    begin
        if (atl_we)
        begin
            atlas_mem[AIDX_W'(texel_addr)] <= texel_data;
        end
        if (cmd.issue)
        begin
            atl_q_reg <= atlas_mem[aidx_reg];
        end
    end

    // canvas memory
    always_ff @(posedge clk)
    begin
        if (cvs_we)
        begin
            canvas_mem[cvs_waddr] <= cvs_wdata;
        end
        if (cmd.issue)
        begin
            cvs_q_reg <= canvas_mem[cidx_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg   <= bfblit_pkg::NARROW_ADV_RST;
            iadv_reg     <= bfblit_pkg::I_ADV_RST;
            dadv_reg     <= bfblit_pkg::DEFAULT_ADV_RST;
            pen_reg      <= '0;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bfblit_pkg::CFG_NARROW_ADV:  narrow_reg <= cfg_data;
                    bfblit_pkg::CFG_I_ADV:       iadv_reg   <= cfg_data;
                    bfblit_pkg::CFG_DEFAULT_ADV: dadv_reg   <= cfg_data;
                    default:                     ;
                endcase
            end
            if (draw_acc)
            begin
                pen_reg <= x0 + PEN_W'(adv_amt);
            end
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= (clr_cnt_reg == C_LAST) ? '0 : clr_cnt_reg + 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg <= cmd.issue;
                s2_valid_reg <= s1_valid_reg;
                o_valid_reg  <= s2_valid_reg;
            end
        end
    end

    // tile walkers: load at accept, step per issued pixel
    always_ff @(posedge clk)
    begin
        if (draw_acc)
        begin
            arow_reg <= row0;
            acol_reg <= col0;
            col0_reg <= col0;
            aidx_reg <= aidx0;
            cx_reg   <= CX_W'(x0);
            x0_reg   <= x0;
            cy_reg   <= y0;
            cidx_reg <= cidx0;
        end
        else if (cmd.issue)
        begin
            if (cmd.row_end)
            begin
                arow_reg <= arow_reg + 1'b1;
                acol_reg <= col0_reg;
                aidx_reg <= aidx_reg + A_ROW_STEP;
                cx_reg   <= CX_W'(x0_reg);
                cy_reg   <= cy_reg + 1'b1;
                cidx_reg <= cidx_reg + C_ROW_STEP;
            end
            else
            begin
                acol_reg <= acol_reg + 1'b1;
                aidx_reg <= aidx_reg + 1'b1;
                cx_reg   <= cx_reg + 1'b1;
                cidx_reg <= cidx_reg + 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: memory reads land, metadata follows
            s1_meta_reg.x    <= cx_reg[bfblit_pkg::OUT_X_W-1:0];
            s1_meta_reg.y    <= cy_reg;
            s1_meta_reg.off  <= off;
            s1_meta_reg.last <= cmd.last;
            s1_atl_ok_reg    <= atl_ok;
            s1_cidx_reg      <= cidx_reg;
            // stage 2: per-channel blend numerators
            s2_meta_reg      <= s1_meta_reg;
            s2_cidx_reg      <= s1_cidx_reg;
            s2_alpha_reg     <= texel[31:24];
            s2_sum_reg[0]    <= blend_sum(texel[23:16], cvs_q_reg[7:0], texel[31:24]);
            s2_sum_reg[1]    <= blend_sum(texel[15:8], cvs_q_reg[15:8], texel[31:24]);
            s2_sum_reg[2]    <= blend_sum(texel[7:0], cvs_q_reg[23:16], texel[31:24]);
            // stage 3: divide and present the beat
            o_x_reg          <= s2_meta_reg.x;
            o_y_reg          <= s2_meta_reg.y;
            o_rgba_reg       <= s2_meta_reg.off ? '0 : blended;
            o_clip_reg       <= s2_meta_reg.off;
            o_last_reg       <= s2_meta_reg.last;
        end
    end

    // outputs
    assign pixel.valid    = o_valid_reg;
    assign pixel.out_x    = o_x_reg;
    assign pixel.out_y    = o_y_reg;
    assign pixel.out_rgba = o_rgba_reg;
    assign pixel.clipped  = o_clip_reg;
    assign pixel.last     = o_last_reg;

    // status
    always_comb
    begin
        sts.adv      = adv;
        sts.empty    = !s1_valid_reg && !s2_valid_reg && !o_valid_reg;
        sts.clr_last = (clr_cnt_reg == C_LAST);
    end

    // write-back and clearing never share the port
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(blend_we && cmd.clr_we))
        else $error("canvas write-back during clearing sweep");

    // sweep counter returns to zero after the last entry
    a_clr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_we && sts.clr_last) |=> (clr_cnt_reg == '0))
        else $error("clear counter did not wrap");

    // last pixel of a glyph leaves an empty pipeline behind it
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_last_reg) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("pixels behind last beat of glyph");

    // an issued pixel enters stage 1
    a_issue_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> s1_valid_reg)
        else $error("issued pixel lost");

endmodule
